[hdl/sxl_pkg.sv]
// shared types, codes and character classes for the s-expression token lexer
`timescale 1ns / 1ps
`default_nettype none

package sxl_pkg;

    localparam int unsigned COUNT_BITS = 16;
    localparam logic [15:0] COUNT_LIMIT = (COUNT_BITS >= 16) ? 16'hFFFF :
        16'((32'd1 << COUNT_BITS) - 32'd1);

    localparam logic [2:0] MODE_IDLE    = 3'd0;
    localparam logic [2:0] MODE_STRING  = 3'd1;
    localparam logic [2:0] MODE_TAG     = 3'd2;
    localparam logic [2:0] MODE_NUM_IN  = 3'd3;
    localparam logic [2:0] MODE_NUM_SEP = 3'd4;
    localparam logic [2:0] MODE_REF     = 3'd5;

    localparam logic [2:0] KIND_STRING  = 3'd0;
    localparam logic [2:0] KIND_OPEN    = 3'd1;
    localparam logic [2:0] KIND_CLOSE   = 3'd2;
    localparam logic [2:0] KIND_TAG     = 3'd3;
    localparam logic [2:0] KIND_NUMBERS = 3'd4;
    localparam logic [2:0] KIND_REF     = 3'd5;
    localparam logic [2:0] KIND_EOS     = 3'd6;

    localparam logic [7:0] CH_NUL    = 8'd0;
    localparam logic [7:0] CH_QUOTE  = 8'd34;
    localparam logic [7:0] CH_OPEN   = 8'd40;
    localparam logic [7:0] CH_CLOSE  = 8'd41;
    localparam logic [7:0] CH_COLON  = 8'd58;
    localparam logic [7:0] CH_AMP    = 8'd38;
    localparam logic [7:0] CH_SPACE  = 8'd32;
    localparam logic [7:0] CH_DOT    = 8'd46;
    localparam logic [7:0] CH_MINUS  = 8'd45;
    localparam logic [7:0] CH_ZERO   = 8'd48;
    localparam logic [7:0] CH_NINE   = 8'd57;
    localparam logic [7:0] CH_LOW_E  = 8'd101;
    localparam logic [7:0] CH_UP_E   = 8'd69;

    typedef struct packed {
        logic [7:0]  text_char;
        logic        char_valid;
        logic        token_end;
        logic [2:0]  token_kind;
        logic [15:0] number_count;
        logic        bad_end;
    } res_t;

    typedef struct packed {
        logic [1:0]  count;
        res_t        res0;
        res_t        res1;
        logic [2:0]  mode_next;
        logic [15:0] total_next;
    } step_t;

    function automatic logic starts_number(input logic [7:0] c);
        starts_number = (c >= CH_ZERO && c <= CH_NINE) || c == CH_DOT || c == CH_MINUS;
    endfunction

    function automatic logic is_number_char(input logic [7:0] c);
        is_number_char = starts_number(c) || c == CH_LOW_E || c == CH_UP_E;
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        is_letter = (c >= 8'd97 && c <= 8'd122) || (c >= 8'd65 && c <= 8'd90);
    endfunction

    function automatic res_t mk_char(input logic [7:0] c);
        res_t r;
        r = '0;
        r.text_char = c;
        r.char_valid = 1'b1;
        mk_char = r;
    endfunction

    function automatic res_t mk_end(input logic [2:0] kind, input logic [15:0] cnt,
                                    input logic bad);
        res_t r;
        r = '0;
        r.token_end = 1'b1;
        r.token_kind = kind;
        r.number_count = cnt;
        r.bad_end = bad;
        mk_end = r;
    endfunction

    function automatic res_t mk_paren(input logic [7:0] c, input logic [2:0] kind);
        res_t r;
        r = '0;
        r.text_char = c;
        r.char_valid = 1'b1;
        r.token_end = 1'b1;
        r.token_kind = kind;
        mk_paren = r;
    endfunction

endpackage

`default_nettype wire

[hdl/sexpr_token_lexer.sv]
// top level of the s-expression token lexer: lexer state and two-entry result buffer
`timescale 1ns / 1ps
`default_nettype none

// One character is taken per beat and decoded combinationally against the lexer
// mode and the number-list count; its zero, one or two results land in a two-entry
// output buffer. While m_tready stays high, characters that give at most one result
// stream at one beat per clock. A character that gives two results
// (a space before a new number, a close after a reference or number list, an end of
// stream inside a token) holds the input while the buffer drains.
// The input is taken whenever the buffer is empty or its last entry leaves in the
// same cycle. Token text leaves as characters, and each token end carries its kind
// on m_tuser with m_tlast high; a number list end carries its count, saturating.

module sexpr_token_lexer
    import sxl_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // ch[7:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // text_char[7:0], char_valid[8],
                                        // number_count[24:9], bad_end[25], zero[31:26]
    output logic             m_tlast,
    output logic [2:0]       m_tuser    // token_kind[2:0]
);

    logic [2:0]  mode_reg, mode_next;
    logic [15:0] total_reg, total_next;
    logic [1:0]  cnt_reg, cnt_next;
    res_t        slot0_reg, slot0_next;
    res_t        slot1_reg, slot1_next;
    step_t       step;
    logic        push, pop;

    sxl_core u_core (
        .ch    (s_tdata),
        .mode  (mode_reg),
        .total (total_reg),
        .step  (step)
    );

    assign m_tvalid = (cnt_reg != 2'd0);
    assign s_tready = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_tready);
    assign push = s_tvalid && s_tready;
    assign pop = m_tvalid && m_tready;

    always_comb
    begin
        mode_next = mode_reg;
        total_next = total_reg;
        cnt_next = cnt_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (push)
        begin
            // buffer is empty once this beat's pop is done
            mode_next = step.mode_next;
            total_next = step.total_next;
            cnt_next = step.count;
            slot0_next = step.res0;
            slot1_next = step.res1;
        end
        else if (pop)
        begin
            cnt_next = cnt_reg - 2'd1;
            slot0_next = slot1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            total_reg <= 16'd0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            mode_reg <= mode_next;
            total_reg <= total_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    assign m_tdata = {6'd0, slot0_reg.bad_end, slot0_reg.number_count,
                      slot0_reg.char_valid, slot0_reg.text_char};
    assign m_tlast = slot0_reg.token_end;
    assign m_tuser = slot0_reg.token_kind;

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("result buffer count out of range");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (cnt_reg == 2'd0 || (cnt_reg == 2'd1 && pop)))
        else $error("beat taken without buffer room");

    a_push_fill: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> cnt_reg == $past(step.count))
        else $error("buffer fill does not match decoded result count");

endmodule

`default_nettype wire

[hdl/sxl_core.sv]
// next-state and result decode for one input character
`timescale 1ns / 1ps
`default_nettype none

module sxl_core
    import sxl_pkg::*;
(
    input  wire logic [7:0]  ch,
    input  wire logic [2:0]  mode,
    input  wire logic [15:0] total,
    output step_t            step
);

    logic [2:0] kind;
    logic [7:0] stop;

    always_comb
    begin
        kind = (mode == MODE_STRING) ? KIND_STRING : KIND_TAG;
        stop = (mode == MODE_STRING) ? CH_QUOTE : CH_COLON;
        step.count = 2'd0;
        step.res0 = '0;
        step.res1 = '0;
        step.mode_next = mode;
        step.total_next = total;
        case (mode)
            MODE_STRING, MODE_TAG:
            begin
                if (ch == CH_NUL)
                begin
                    step.count = 2'd2;
                    step.res0 = mk_end(kind, 16'd0, 1'b1);
                    step.res1 = mk_end(KIND_EOS, 16'd0, 1'b0);
                    step.mode_next = MODE_IDLE;
                end
                else if (ch == stop)
                begin
                    step.count = 2'd1;
                    step.res0 = mk_end(kind, 16'd0, 1'b0);
                    step.mode_next = MODE_IDLE;
                end
                else
                begin
                    step.count = 2'd1;
                    step.res0 = mk_char(ch);
                end
            end
            MODE_REF:
            begin
                if (ch == CH_NUL)
                begin
                    step.count = 2'd2;
                    step.res0 = mk_end(KIND_REF, 16'd0, 1'b1);
                    step.res1 = mk_end(KIND_EOS, 16'd0, 1'b0);
                    step.mode_next = MODE_IDLE;
                end
                else if (ch == CH_CLOSE)
                begin
                    step.count = 2'd2;
                    step.res0 = mk_end(KIND_REF, 16'd0, 1'b0);
                    step.res1 = mk_paren(CH_CLOSE, KIND_CLOSE);
                    step.mode_next = MODE_IDLE;
                end
                else
                begin
                    step.count = 2'd1;
                    step.res0 = mk_char(ch);
                end
            end
            MODE_NUM_IN, MODE_NUM_SEP:
            begin
                if (ch == CH_NUL)
                begin
                    step.count = 2'd2;
                    step.res0 = mk_end(KIND_NUMBERS, total, 1'b1);
                    step.res1 = mk_end(KIND_EOS, 16'd0, 1'b0);
                    step.mode_next = MODE_IDLE;
                end
                else if (ch == CH_CLOSE)
                begin
                    step.count = 2'd2;
                    step.res0 = mk_end(KIND_NUMBERS, total, 1'b0);
                    step.res1 = mk_paren(CH_CLOSE, KIND_CLOSE);
                    step.mode_next = MODE_IDLE;
                end
                else if (is_number_char(ch))
                begin
                    if (mode == MODE_NUM_SEP)
                    begin
                        step.count = 2'd2;
                        step.res0 = mk_char(CH_SPACE);
                        step.res1 = mk_char(ch);
                        if (total < COUNT_LIMIT)
                        begin
                            step.total_next = total + 16'd1;
                        end
                        step.mode_next = MODE_NUM_IN;
                    end
                    else
                    begin
                        step.count = 2'd1;
                        step.res0 = mk_char(ch);
                    end
                end
                else
                begin
                    step.mode_next = MODE_NUM_SEP;
                end
            end
            default:
            begin
                step.mode_next = MODE_IDLE;
                if (ch == CH_NUL)
                begin
                    step.count = 2'd1;
                    step.res0 = mk_end(KIND_EOS, 16'd0, 1'b0);
                end
                else if (ch == CH_QUOTE)
                begin
                    step.mode_next = MODE_STRING;
                end
                else if (ch == CH_OPEN)
                begin
                    step.count = 2'd1;
                    step.res0 = mk_paren(ch, KIND_OPEN);
                end
                else if (is_letter(ch))
                begin
                    step.count = 2'd1;
                    step.res0 = mk_char(ch);
                    step.mode_next = MODE_TAG;
                end
                else if (starts_number(ch))
                begin
                    step.count = 2'd1;
                    step.res0 = mk_char(ch);
                    step.total_next = (COUNT_LIMIT != 16'd0) ? 16'd1 : 16'd0;
                    step.mode_next = MODE_NUM_IN;
                end
                else if (ch == CH_CLOSE)
                begin
                    step.count = 2'd1;
                    step.res0 = mk_paren(ch, KIND_CLOSE);
                end
                else if (ch == CH_AMP)
                begin
                    step.mode_next = MODE_REF;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

[tb/sexpr_token_lexer_tb.sv]
// self-checking testbench for the s-expression token lexer
`timescale 1ns / 1ps

module sexpr_token_lexer_tb;
    import sxl_pkg::*;

    localparam logic [7:0] CH_TAB = 8'd9;
    localparam int RANDOM_ITEMS = 1850;
    localparam int LONG_HOLD = 300;

    class lexer_scoreboard;
        logic [2:0] mode;
        logic [15:0] total;
        res_t token_beats_due[$];
        int beats;
        int errors;

        function new();
            mode = MODE_IDLE;
            total = '0;
            beats = 0;
            errors = 0;
        endfunction

        static function bit opens_number(input logic [7:0] c);
            return (c >= CH_ZERO && c <= CH_NINE) || c == CH_DOT || c == CH_MINUS;
        endfunction

        static function bit in_number(input logic [7:0] c);
            return opens_number(c) || c == CH_LOW_E || c == CH_UP_E;
        endfunction

        static function bit is_alpha(input logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        endfunction

        function void push_text(input logic [7:0] c);
            res_t r;
            r = '0;
            r.text_char = c;
            r.char_valid = 1'b1;
            token_beats_due.push_back(r);
        endfunction

        function void push_end(input logic [2:0] kind, input logic [15:0] cnt, input logic bad);
            res_t r;
            r = '0;
            r.token_end = 1'b1;
            r.token_kind = kind;
            r.number_count = cnt;
            r.bad_end = bad;
            token_beats_due.push_back(r);
        endfunction

        function void push_paren(input logic [7:0] c, input logic [2:0] kind);
            res_t r;
            r = '0;
            r.text_char = c;
            r.char_valid = 1'b1;
            r.token_end = 1'b1;
            r.token_kind = kind;
            token_beats_due.push_back(r);
        endfunction

        function int pending();
            return token_beats_due.size();
        endfunction

        // accepted input character: work out the beats it causes
        function void take_char(input logic [7:0] c);
            logic [2:0] kind;
            logic [7:0] stop;
            case (mode)
                MODE_STRING, MODE_TAG:
                begin
                    kind = (mode == MODE_STRING) ? KIND_STRING : KIND_TAG;
                    stop = (mode == MODE_STRING) ? CH_QUOTE : CH_COLON;
                    if (c == CH_NUL)
                    begin
                        push_end(kind, '0, 1'b1);
                        push_end(KIND_EOS, '0, 1'b0);
                        mode = MODE_IDLE;
                    end
                    else if (c == stop)
                    begin
                        push_end(kind, '0, 1'b0);
                        mode = MODE_IDLE;
                    end
                    else
                        push_text(c);
                end
                MODE_REF:
                begin
                    if (c == CH_NUL)
                    begin
                        push_end(KIND_REF, '0, 1'b1);
                        push_end(KIND_EOS, '0, 1'b0);
                        mode = MODE_IDLE;
                    end
                    else if (c == CH_CLOSE)
                    begin
                        push_end(KIND_REF, '0, 1'b0);
                        push_paren(CH_CLOSE, KIND_CLOSE);
                        mode = MODE_IDLE;
                    end
                    else
                        push_text(c);
                end
                MODE_NUM_IN, MODE_NUM_SEP:
                begin
                    if (c == CH_NUL)
                    begin
                        push_end(KIND_NUMBERS, total, 1'b1);
                        push_end(KIND_EOS, '0, 1'b0);
                        mode = MODE_IDLE;
                    end
                    else if (c == CH_CLOSE)
                    begin
                        push_end(KIND_NUMBERS, total, 1'b0);
                        push_paren(CH_CLOSE, KIND_CLOSE);
                        mode = MODE_IDLE;
                    end
                    else if (in_number(c))
                    begin
                        if (mode == MODE_NUM_SEP)
                        begin
                            push_text(CH_SPACE);
                            if (total < COUNT_LIMIT)
                                total = total + 16'd1;
                            mode = MODE_NUM_IN;
                        end
                        push_text(c);
                    end
                    else
                        mode = MODE_NUM_SEP;
                end
                default:
                begin
                    mode = MODE_IDLE;
                    if (c == CH_NUL)
                        push_end(KIND_EOS, '0, 1'b0);
                    else if (c == CH_QUOTE)
                        mode = MODE_STRING;
                    else if (c == CH_OPEN)
                        push_paren(c, KIND_OPEN);
                    else if (is_alpha(c))
                    begin
                        push_text(c);
                        mode = MODE_TAG;
                    end
                    else if (opens_number(c))
                    begin
                        push_text(c);
                        total = 16'd1;
                        mode = MODE_NUM_IN;
                    end
                    else if (c == CH_CLOSE)
                        push_paren(CH_CLOSE, KIND_CLOSE);
                    else if (c == CH_AMP)
                        mode = MODE_REF;
                end
            endcase
        endfunction

        task report(input string msg);
            if (errors < 40)
                $display("%0t ns beat %0d: %s", $time, beats, msg);
            errors++;
        endtask

        task check_beat(input res_t got, input logic [5:0] pad);
            res_t want;
            beats++;
            if (token_beats_due.size() == 0)
                report($sformatf("unexpected beat %h", got));
            else
            begin
                want = token_beats_due.pop_front();
                if (got.text_char !== want.text_char)
                    report($sformatf("text_char %h, want %h", got.text_char, want.text_char));
                if (got.char_valid !== want.char_valid)
                    report($sformatf("char_valid %b, want %b", got.char_valid, want.char_valid));
                if (got.token_end !== want.token_end)
                    report($sformatf("token_end %b, want %b", got.token_end, want.token_end));
                if (got.token_kind !== want.token_kind)
                    report($sformatf("token_kind %0d, want %0d", got.token_kind,
                                     want.token_kind));
                if (got.number_count !== want.number_count)
                    report($sformatf("number_count %0d, want %0d", got.number_count,
                                     want.number_count));
                if (got.bad_end !== want.bad_end)
                    report($sformatf("bad_end %b, want %b", got.bad_end, want.bad_end));
            end
            if (pad !== 6'd0)
                report($sformatf("tdata padding %b", pad));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic [2:0]  m_tuser;

    lexer_scoreboard sb;
    int sent = 0;
    bit hold_request = 1'b0;

    sexpr_token_lexer uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #40_000_000;
        $display("sexpr_token_lexer_tb: errors");
        $finish;
    end

    always @(posedge clk)
    begin
        res_t got;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.take_char(s_tdata);
            if (m_tvalid && m_tready)
            begin
                got.text_char = m_tdata[7:0];
                got.char_valid = m_tdata[8];
                got.number_count = m_tdata[24:9];
                got.bad_end = m_tdata[25];
                got.token_end = m_tlast;
                got.token_kind = m_tuser;
                sb.check_beat(got, m_tdata[31:26]);
            end
        end
    end

    // result side: random stalls, steady stretches and one long hold
    initial
    begin : rx_side
        int stall_left;
        int r;
        bit steady;
        stall_left = 0;
        steady = 1'b0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                m_tready = 1'b0;
                stall_left--;
            end
            else if (steady)
                m_tready = 1'b1;
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 80)
                    m_tready = 1'b1;
                else
                begin
                    m_tready = 1'b0;
                    stall_left = (r < 97) ? $urandom_range(0, 2) : $urandom_range(8, 40);
                end
            end
            if ($urandom_range(0, 199) == 0)
                steady = !steady;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] pick_byte(input logic [7:0] avoid);
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (c == avoid);
        return c;
    endfunction

    function automatic logic [7:0] pick_separator();
        logic [7:0] c;
        case ($urandom_range(0, 3))
            0: return CH_SPACE;
            1: return CH_TAB;
            default:
            begin
                do
                    c = 8'($urandom_range(1, 255));
                while (lexer_scoreboard::in_number(c) || c == CH_CLOSE);
                return c;
            end
        endcase
    endfunction

    function automatic logic [7:0] num_glyph(input bit first);
        int r;
        r = first ? $urandom_range(0, 11) : $urandom_range(0, 13);
        case (r)
            10: return CH_DOT;
            11: return CH_MINUS;
            12: return CH_LOW_E;
            13: return CH_UP_E;
            default: return CH_ZERO + 8'(r);
        endcase
    endfunction

    // entered just after a rising edge, returns at the edge that takes the beat
    task automatic send_char(input logic [7:0] c, input bit gaps);
        int idle;
        idle = gaps ? pick_gap() : 0;
        @(negedge clk);
        if (idle > 0)
        begin
            s_tvalid = 1'b0;
            repeat (idle) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata = c;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent++;
    endtask

    task automatic send_phrase(input bit gaps);
        int r;
        int len;
        int nums;
        int k;
        int j;
        logic [7:0] opener;
        logic [7:0] stop;
        r = $urandom_range(0, 99);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
        if (r < 14)
            send_char(CH_OPEN, gaps);
        else if (r < 24)
            send_char(CH_CLOSE, gaps);
        else if (r < 66)
        begin
            case (r % 3)
                0:
                begin
                    opener = CH_QUOTE;
                    stop = CH_QUOTE;
                end
                1:
                begin
                    opener = ($urandom_range(0, 1) ? "A" : "a") + 8'($urandom_range(0, 25));
                    stop = CH_COLON;
                end
                default:
                begin
                    opener = CH_AMP;
                    stop = CH_CLOSE;
                end
            endcase
            send_char(opener, gaps);
            repeat (len) send_char(pick_byte(stop), gaps);
            send_char(($urandom_range(0, 19) == 0) ? CH_NUL : stop, gaps);
        end
        else if (r < 90)
        begin
            nums = $urandom_range(1, 6);
            send_char(num_glyph(1'b1), gaps);
            for (k = 0; k < nums; k++)
            begin
                repeat ($urandom_range(0, 3)) send_char(num_glyph(1'b0), gaps);
                if (k < nums - 1)
                begin
                    for (j = 0; j < $urandom_range(1, 2); j++)
                        send_char(pick_separator(), gaps);
                    send_char(num_glyph(1'b0), gaps);
                end
            end
            r = $urandom_range(0, 19);
            if (r < 17)
                send_char(CH_CLOSE, gaps);
            else if (r < 19)
                send_char(CH_NUL, gaps);
        end
        else if (r < 98)
            send_char(8'($urandom_range(0, 255)), gaps);
        else
            send_char(CH_NUL, gaps);
    endtask

    initial
    begin : stimulus
        logic [7:0] opening [29];
        int mark;
        int burst;
        bit held;
        bit paused;
        opening = '{CH_NUL, CH_OPEN, "a", 8'hFF, CH_COLON, CH_QUOTE, "k", 8'h01, CH_QUOTE,
                    CH_QUOTE, CH_NUL, CH_AMP, "x", CH_CLOSE, CH_MINUS, CH_LOW_E, CH_SPACE,
                    CH_UP_E, CH_TAB, CH_DOT, CH_CLOSE, CH_NINE, CH_NUL, "Q", CH_NUL, CH_AMP,
                    CH_NUL, CH_CLOSE, 8'h80};
        burst = 0;
        held = 1'b0;
        paused = 1'b0;
        sb = new();
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (opening[i])
            send_char(opening[i], 1'b1);

        mark = sent;
        while (sent - mark < RANDOM_ITEMS)
        begin
            if (!held && sent - mark >= 600)
            begin
                held = 1'b1;
                hold_request = 1'b1;
                burst = 60;
            end
            if (!paused && sent - mark >= 1200)
            begin
                paused = 1'b1;
                @(negedge clk);
                s_tvalid = 1'b0;
                while (sb.pending() != 0)
                    @(posedge clk);
            end
            if (burst == 0 && $urandom_range(0, 39) == 0)
                burst = $urandom_range(20, 80);
            send_phrase(burst == 0);
            if (burst > 0)
                burst--;
        end

        @(negedge clk);
        s_tvalid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("sexpr_token_lexer_tb: clean");
        else
            $display("sexpr_token_lexer_tb: errors");
        $finish;
    end

endmodule
